// ===== design/chp_pkg.sv =====
// ----------------------------------------------------------------------------
// chp_pkg
// Shared types and constants for the chunked-body parser core.
// ----------------------------------------------------------------------------
package chp_pkg;

  localparam int SIZE_BITS_DEF = 31;  // default width of the chunk size counter
  localparam int OUT_SIZE_W    = 31;  // width of the size_value result field
  localparam int Q_DEPTH       = 2;   // front-to-back queue entries, power of two

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  localparam logic CMD_FEED    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // One classified stream transaction, as queued between front and back.
  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
    logic       is_ws;
    logic       is_cr;
    logic       is_lf;
    logic       hex_ok;
    logic [3:0] hex_val;
  } chp_item_t;

  typedef enum logic [7:0] {
    PH_WAIT_SIZE = 8'b0000_0001,
    PH_SIZE      = 8'b0000_0010,
    PH_WAIT_CR   = 8'b0000_0100,
    PH_WAIT_LF   = 8'b0000_1000,
    PH_ZERO_CR   = 8'b0001_0000,
    PH_ZERO_LF   = 8'b0010_0000,
    PH_PAYLOAD   = 8'b0100_0000,
    PH_DONE      = 8'b1000_0000
  } chp_phase_t;

  typedef struct packed {
    logic                  byte_consumed;
    logic                  payload_valid;
    logic [7:0]            payload_byte;
    logic                  chunk_done;
    logic                  last_chunk;
    logic [OUT_SIZE_W-1:0] size_value;
  } chp_result_t;

endpackage

// ===== design/chp_if.sv =====
// ----------------------------------------------------------------------------
// chp_if
// Valid/ready channel interfaces for stream input and parse results.
// ----------------------------------------------------------------------------
interface chp_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface chp_out_if;
  logic        valid;
  logic        ready;
  logic        byte_consumed;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic        chunk_done;
  logic        last_chunk;
  logic [30:0] size_value;

  modport source (output valid, output byte_consumed, output payload_valid,
                  output payload_byte, output chunk_done, output last_chunk,
                  output size_value, input ready);
  modport sink   (input valid, input byte_consumed, input payload_valid,
                  input payload_byte, input chunk_done, input last_chunk,
                  input size_value, output ready);
endinterface

// ===== design/http_chunk_header_and_body_parser_core.sv =====
// ----------------------------------------------------------------------------
// http_chunk_header_and_body_parser_core
// Chunked-transfer header and body parser, one stream byte per transaction.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------
//  in_ch   | in  | valid/ready        | command, data_byte
//  out_ch  | out | valid/ready        | byte_consumed, payload_valid,
//          |     |                    | payload_byte, chunk_done, last_chunk,
//          |     |                    | size_value
//
//  Cycles: one transaction per clock sustained while out_ch.ready stays high;
//    an input is written to the queue at the accepting edge, and its result is
//    later taken into the result reg together with the state machine update.
//    Rate is set by the parser update in the back end.
//  Reset: synchronous active-low rst_n clears queue pointers, parser state and
//    the output valid; no clearing pass.
//  Stalls: a two-entry queue decouples intake from the back end, and the result
//    register holds while out_ch.ready is low; in_ch.ready drops only when the
//    queue is full.
//
module http_chunk_header_and_body_parser_core #(
  parameter int SIZE_BITS = chp_pkg::SIZE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  chp_in_if.sink    in_ch,
  chp_out_if.source out_ch
);
  import chp_pkg::*;

  // front -> queue
  logic      push;
  chp_item_t push_item;
  logic      q_full;

  // queue -> back
  logic      pop;
  logic      q_avail;
  chp_item_t pop_item;

  // Front: byte classification (whitespace, CR, LF, hex digit value).
  chp_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (push),
    .q_item (push_item)
  );

  // Queue lets intake run while results back up, and vice versa.
  chp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .avail     (q_avail),
    .pop_item  (pop_item)
  );

  // Back: size token accumulation, CR/LF tracking, payload count, result reg.
  chp_back #(
    .SIZE_BITS (SIZE_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_avail (q_avail),
    .q_item  (pop_item),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== design/chp_front.sv =====
// ----------------------------------------------------------------------------
// chp_front
// Accepts stream transactions and classifies the byte for the back end.
// ----------------------------------------------------------------------------
module chp_front (
  chp_in_if.sink             in_ch,
  input  logic               q_full,
  output logic               q_push,
  output chp_pkg::chp_item_t q_item
);
  import chp_pkg::*;

  logic [7:0] c;

  assign c            = in_ch.data_byte;
  assign in_ch.ready  = !q_full;
  assign q_push       = in_ch.valid && !q_full;

  always_comb begin
    q_item           = '0;
    q_item.command   = in_ch.command;
    q_item.data_byte = c;
    q_item.is_ws     = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    q_item.is_cr     = (c == CH_CR);
    q_item.is_lf     = (c == CH_LF);
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      q_item.hex_ok  = 1'b1;
      q_item.hex_val = c[3:0];
    end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
      // letters a-f / A-F: low nibble 1..6 maps to 10..15
      q_item.hex_ok  = 1'b1;
      q_item.hex_val = c[3:0] + 4'd9;
    end
  end

endmodule

// ===== design/chp_queue.sv =====
// ----------------------------------------------------------------------------
// chp_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module chp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  chp_pkg::chp_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               avail,
  output chp_pkg::chp_item_t pop_item
);
  import chp_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(Q_DEPTH);

  chp_item_t        mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == DEPTH_C);
  assign avail    = (cnt_r != '0);
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== design/chp_back.sv =====
// ----------------------------------------------------------------------------
// chp_back
// Parser state machine and result register; one queued item per cycle while the result register is free or being taken.
// ----------------------------------------------------------------------------
module chp_back #(
  parameter int SIZE_BITS = chp_pkg::SIZE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_avail,
  input  chp_pkg::chp_item_t q_item,
  output logic               q_pop,
  chp_out_if.source          out_ch
);
  import chp_pkg::*;

  chp_phase_t           phase_r, phase_nxt;
  logic [SIZE_BITS-1:0] accum_r, accum_nxt;
  logic                 open_r, open_nxt;
  logic [SIZE_BITS-1:0] count_r, count_nxt;
  logic [SIZE_BITS-1:0] count_inc;
  logic [SIZE_BITS-1:0] accum_dig;
  logic                 accum_sat;
  logic [SIZE_BITS+OUT_SIZE_W-1:0] size_ext;

  logic        out_valid_r;
  chp_result_t res_r, res_nxt;

  assign q_pop     = q_avail && (!out_valid_r || out_ch.ready);
  assign count_inc = count_r + SIZE_BITS'(1);
  // top nibble set means one more digit would exceed the max: saturate
  assign accum_sat = (accum_r[SIZE_BITS-1 -: 4] != 4'd0);
  assign accum_dig = accum_sat ? '1 : {accum_r[SIZE_BITS-5:0], q_item.hex_val};
  assign size_ext  = {{OUT_SIZE_W{1'b0}}, accum_nxt};

  always_comb begin
    phase_nxt = phase_r;
    accum_nxt = accum_r;
    open_nxt  = open_r;
    count_nxt = count_r;
    res_nxt   = '0;

    case (phase_r)
      PH_WAIT_SIZE: begin
        res_nxt.byte_consumed = 1'b1;
        if (!q_item.is_ws) begin
          accum_nxt = q_item.hex_ok ? SIZE_BITS'(q_item.hex_val) : '0;
          open_nxt  = q_item.hex_ok;
          phase_nxt = PH_SIZE;
        end
      end
      PH_SIZE: begin
        res_nxt.byte_consumed = 1'b1;
        if (q_item.is_ws) begin
          phase_nxt = q_item.is_cr ? PH_WAIT_LF : PH_WAIT_CR;
        end else if (open_r) begin
          if (q_item.hex_ok) begin
            accum_nxt = accum_dig;
          end else begin
            open_nxt = 1'b0;
          end
        end
      end
      PH_WAIT_CR: begin
        res_nxt.byte_consumed = 1'b1;
        if (q_item.is_cr) phase_nxt = PH_WAIT_LF;
      end
      PH_WAIT_LF: begin
        res_nxt.byte_consumed = 1'b1;
        if (q_item.is_lf) begin
          count_nxt = '0;
          phase_nxt = (accum_r == '0) ? PH_ZERO_CR : PH_PAYLOAD;
        end
      end
      PH_ZERO_CR: begin
        res_nxt.byte_consumed = 1'b1;
        if (q_item.is_cr) phase_nxt = PH_ZERO_LF;
      end
      PH_ZERO_LF: begin
        res_nxt.byte_consumed = 1'b1;
        if (q_item.is_lf) phase_nxt = PH_DONE;
      end
      PH_PAYLOAD: begin
        res_nxt.byte_consumed = 1'b1;
        res_nxt.payload_valid = 1'b1;
        res_nxt.payload_byte  = q_item.data_byte;
        count_nxt             = count_inc;
        if (count_inc >= accum_r) phase_nxt = PH_DONE;
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase

    res_nxt.chunk_done = (phase_nxt == PH_DONE);
    res_nxt.last_chunk = ((phase_nxt == PH_ZERO_CR) || (phase_nxt == PH_ZERO_LF) ||
                          (phase_nxt == PH_DONE)) && (accum_nxt == '0);
    res_nxt.size_value = size_ext[OUT_SIZE_W-1:0];

    if (q_item.command == CMD_RESTART) begin
      phase_nxt = PH_WAIT_SIZE;
      accum_nxt = '0;
      open_nxt  = 1'b1;
      count_nxt = '0;
      res_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WAIT_SIZE;
      accum_r     <= '0;
      open_r      <= 1'b1;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r <= phase_nxt;
        accum_r <= accum_nxt;
        open_r  <= open_nxt;
        count_r <= count_nxt;
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) res_r <= res_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.byte_consumed = res_r.byte_consumed;
  assign out_ch.payload_valid = res_r.payload_valid;
  assign out_ch.payload_byte  = res_r.payload_byte;
  assign out_ch.chunk_done    = res_r.chunk_done;
  assign out_ch.last_chunk    = res_r.last_chunk;
  assign out_ch.size_value    = res_r.size_value;

endmodule

// ===== design/chp_checker.sv =====
// ----------------------------------------------------------------------------
// chp_checker
// Port-level checks on the parser core's result channel.
// ----------------------------------------------------------------------------
module chp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_byte_consumed,
  input logic        out_payload_valid,
  input logic [7:0]  out_payload_byte,
  input logic        out_last_chunk,
  input logic [30:0] out_size_value
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload_byte)
      && $stable(out_size_value) && $stable(out_payload_valid))
    else $error("result changed while stalled");

  a_payload_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload_valid |-> out_byte_consumed)
    else $error("payload byte not marked consumed");

  a_payload_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload_valid |-> !out_last_chunk)
    else $error("payload byte in a zero-size chunk");

  a_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_chunk |-> (out_size_value == 31'd0))
    else $error("last chunk with nonzero size");

endmodule

bind http_chunk_header_and_body_parser_core chp_checker u_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_byte_consumed (out_ch.byte_consumed),
  .out_payload_valid (out_ch.payload_valid),
  .out_payload_byte  (out_ch.payload_byte),
  .out_last_chunk    (out_ch.last_chunk),
  .out_size_value    (out_ch.size_value)
);
